@@ sv/hrsp_pkg.sv @@
// Shared types, codes and character tests for the HTTP request stream parser.
`timescale 1ns / 1ps
`default_nettype none

package hrsp_pkg;

	localparam int GAP_COUNT_BITS_DEF = 16;
	localparam int GAP_OUT_BITS       = 16;

	// Results one byte can cause, and the output queue behind the step logic
	localparam int RES_MAX         = 3;
	localparam int RES_COUNT_BITS  = $clog2(RES_MAX + 1);
	localparam int FIFO_DEPTH      = 4;
	localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS   = $clog2(FIFO_DEPTH + 1);

	// Result kinds; method, uri and version are the token number minus one
	localparam logic [2:0] KIND_KEY    = 3'd3;
	localparam logic [2:0] KIND_VALUE  = 3'd4;
	localparam logic [2:0] KIND_BODY   = 3'd5;
	localparam logic [2:0] KIND_STATUS = 3'd6;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_TOKEN_COUNT = 3'd1;
	localparam logic [2:0] ST_BAD_METHOD  = 3'd2;
	localparam logic [2:0] ST_BAD_VERSION = 3'd3;
	localparam logic [2:0] ST_NO_COLON    = 3'd4;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Token numbers within the start line
	localparam logic [2:0] TOKEN_METHOD  = 3'd1;
	localparam logic [2:0] TOKEN_VERSION = 3'd3;
	localparam logic [2:0] TOKEN_CAP     = 3'd4;
	localparam logic [3:0] POS_CAP       = 4'd15;
	localparam logic [3:0] VERSION_LEN   = 4'd8;

	// Candidate bits: 0 GET, 1 POST, 2 DELETE
	localparam logic [2:0] METHOD_ALL = 3'b111;

	typedef enum logic [2:0] {
		PH_START,
		PH_KEY,
		PH_VALUE,
		PH_BODY,
		PH_ERROR
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_request;
	} req_item_t;

	typedef struct packed {
		logic [2:0]              kind;
		logic [7:0]              char_value;
		logic                    is_boundary;
		logic [GAP_OUT_BITS-1:0] gap_spaces;
		logic [2:0]              status;
		logic                    tail_dropped;
		logic                    last_of_run;
	} res_item_t;

	typedef struct packed {
		phase_t     phase;
		logic       cr_held;
		logic [2:0] token_count;
		logic       in_token;
		logic [2:0] method_cand;
		logic [3:0] token_position;
		logic       version_match;
		logic       value_started;
		logic       line_has_bytes;
		logic [2:0] error_code;
	} parser_ctl_t;

	typedef struct packed {
		logic [RES_COUNT_BITS-1:0]  count;
		res_item_t [RES_MAX-1:0]    slot;
	} step_out_t;

	localparam parser_ctl_t CTL_RESET = '{
		phase:          PH_START,
		cr_held:        1'b0,
		token_count:    3'd0,
		in_token:       1'b0,
		method_cand:    METHOD_ALL,
		token_position: 4'd0,
		version_match:  1'b1,
		value_started:  1'b0,
		line_has_bytes: 1'b0,
		error_code:     ST_OK
	};

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// Methods still matching character c at position pos
	function automatic logic [2:0] method_char_hits(input logic [3:0] pos, input logic [7:0] c);
		logic [2:0] h;
		h = '0;
		case (pos)
			4'd0:    h = {c == "D", c == "P", c == "G"};
			4'd1:    h = {c == "E", c == "O", c == "E"};
			4'd2:    h = {c == "L", c == "S", c == "T"};
			4'd3:    h = {c == "E", c == "T", 1'b0};
			4'd4:    h = {c == "T", 2'b00};
			4'd5:    h = {c == "E", 2'b00};
			default: h = '0;
		endcase
		return h;
	endfunction

	function automatic logic [2:0] method_len_mask(input logic [3:0] len);
		return {len == 4'd6, len == 4'd4, len == 4'd3};
	endfunction

	function automatic logic version_char_hit(input logic [3:0] pos, input logic [7:0] c);
		logic h;
		h = 1'b0;
		case (pos)
			4'd0:    h = (c == "H");
			4'd1:    h = (c == "T");
			4'd2:    h = (c == "T");
			4'd3:    h = (c == "P");
			4'd4:    h = (c == "/");
			4'd5:    h = (c == "1");
			4'd6:    h = (c == ".");
			4'd7:    h = (c == "1");
			default: h = 1'b0;
		endcase
		return h;
	endfunction

	// Close the open start-line token and settle its length checks
	function automatic parser_ctl_t end_token(input parser_ctl_t s);
		parser_ctl_t r;
		r = s;
		r.in_token = 1'b0;
		if (s.token_count == TOKEN_METHOD) begin
			r.method_cand = s.method_cand & method_len_mask(s.token_position);
		end else if (s.token_count == TOKEN_VERSION && s.token_position != VERSION_LEN) begin
			r.version_match = 1'b0;
		end
		return r;
	endfunction

	// Tokens after the third are not reported
	function automatic logic token_emits(input parser_ctl_t s);
		return (s.token_count != 3'd0) && (s.token_count <= TOKEN_VERSION);
	endfunction

	function automatic res_item_t token_boundary(input parser_ctl_t s);
		res_item_t r;
		r = '0;
		r.kind = s.token_count - 3'd1;
		r.is_boundary = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/hrsp_byte.sv @@
// Handling of one data byte in the start line, a header key or a header value.
`timescale 1ns / 1ps
`default_nettype none

module hrsp_byte
	import hrsp_pkg::*;
#(
	parameter int GAP_COUNT_BITS = GAP_COUNT_BITS_DEF
) (
	input  logic                      en,
	input  logic [7:0]                char_value,
	input  parser_ctl_t               ctl_in,
	input  logic [GAP_COUNT_BITS-1:0] gap_in,
	output parser_ctl_t               ctl_out,
	output logic [GAP_COUNT_BITS-1:0] gap_out,
	output logic                      emit_valid,
	output res_item_t                 emit
);

	logic [GAP_OUT_BITS-1:0] gap_sat;
	logic [2:0]              tc;
	logic [3:0]              pos;

	generate
		if (GAP_COUNT_BITS > GAP_OUT_BITS) begin : g_cap
			assign gap_sat = (|gap_in[GAP_COUNT_BITS-1:GAP_OUT_BITS]) ? '1
				: gap_in[GAP_OUT_BITS-1:0];
		end else begin : g_ext
			assign gap_sat = GAP_OUT_BITS'(gap_in);
		end
	endgenerate

	always_comb begin
		ctl_out    = ctl_in;
		gap_out    = gap_in;
		emit_valid = 1'b0;
		emit       = '0;
		tc         = ctl_in.token_count;
		pos        = ctl_in.token_position;
		if (en) begin
			case (ctl_in.phase)
				PH_START: begin
					ctl_out.line_has_bytes = 1'b1;
					if (is_ws(char_value)) begin
						if (ctl_in.in_token) begin
							ctl_out    = end_token(ctl_out);
							emit_valid = token_emits(ctl_in);
							emit       = token_boundary(ctl_in);
						end
					end else begin
						if (!ctl_in.in_token) begin
							ctl_out.in_token = 1'b1;
							pos = '0;
							if (tc < TOKEN_CAP) begin
								tc = tc + 3'd1;
							end
						end
						if (tc == TOKEN_METHOD) begin
							ctl_out.method_cand = ctl_in.method_cand
								& method_char_hits(pos, char_value);
						end else if (tc == TOKEN_VERSION) begin
							ctl_out.version_match = ctl_in.version_match
								& version_char_hit(pos, char_value);
						end
						ctl_out.token_count    = tc;
						ctl_out.token_position = (pos < POS_CAP) ? pos + 4'd1 : pos;
						emit_valid      = (tc <= TOKEN_VERSION);
						emit.kind       = tc - 3'd1;
						emit.char_value = char_value;
					end
				end
				PH_KEY: begin
					ctl_out.line_has_bytes = 1'b1;
					emit_valid = 1'b1;
					emit.kind  = KIND_KEY;
					if (char_value == CH_COLON) begin
						emit.is_boundary      = 1'b1;
						ctl_out.phase         = PH_VALUE;
						ctl_out.value_started = 1'b0;
						gap_out               = '0;
					end else begin
						emit.char_value = to_lower(char_value);
					end
				end
				PH_VALUE: begin
					ctl_out.line_has_bytes = 1'b1;
					if (char_value == CH_SPACE) begin
						// count only inner spaces, saturating
						if (ctl_in.value_started && !(&gap_in)) begin
							gap_out = gap_in + GAP_COUNT_BITS'(1);
						end
					end else begin
						emit_valid            = 1'b1;
						emit.kind             = KIND_VALUE;
						emit.char_value       = to_lower(char_value);
						emit.gap_spaces       = gap_sat;
						gap_out               = '0;
						ctl_out.value_started = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/hrsp_core.sv @@
// Parser state and the per-byte step that yields up to three results.
`timescale 1ns / 1ps
`default_nettype none

module hrsp_core
	import hrsp_pkg::*;
#(
	parameter int GAP_COUNT_BITS = GAP_COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t item,
	input  logic      advance,
	output step_out_t step
);

	parser_ctl_t               ctl_q;
	logic [GAP_COUNT_BITS-1:0] gap_q;

	parser_ctl_t               ctl_a, ctl_b, ctl_c, ctl_l, ctl_post, ctl_next;
	logic [GAP_COUNT_BITS-1:0] gap_b, gap_c, gap_post;
	logic                      active, line_end, en_a, en_b;
	logic                      ev_a, ev_b, ev_l;
	res_item_t                 r_a, r_b, r_l;
	logic [2:0]                err;
	logic [3:0]                cand_v;
	res_item_t [3:0]           cand_r;
	logic [RES_COUNT_BITS-1:0] n;

	assign active   = (ctl_q.phase != PH_BODY) && (ctl_q.phase != PH_ERROR);
	assign line_end = active && ctl_q.cr_held && (item.byte_value == CH_LF);
	// a held CR not followed by LF is data before the current byte
	assign en_a     = active && ctl_q.cr_held && (item.byte_value != CH_LF);
	assign en_b     = active && !line_end && (item.byte_value != CH_CR);

	always_comb begin
		ctl_a = ctl_q;
		ctl_a.cr_held = 1'b0;
	end

	hrsp_byte #(
		.GAP_COUNT_BITS(GAP_COUNT_BITS)
	) u_byte_cr (
		.en         (en_a),
		.char_value (CH_CR),
		.ctl_in     (ctl_a),
		.gap_in     (gap_q),
		.ctl_out    (ctl_b),
		.gap_out    (gap_b),
		.emit_valid (ev_a),
		.emit       (r_a)
	);

	hrsp_byte #(
		.GAP_COUNT_BITS(GAP_COUNT_BITS)
	) u_byte_cur (
		.en         (en_b),
		.char_value (item.byte_value),
		.ctl_in     (ctl_b),
		.gap_in     (gap_b),
		.ctl_out    (ctl_c),
		.gap_out    (gap_c),
		.emit_valid (ev_b),
		.emit       (r_b)
	);

	// End of line on CR LF
	always_comb begin
		ctl_l = ctl_b;
		ev_l  = 1'b0;
		r_l   = '0;
		err   = ST_OK;
		case (ctl_b.phase)
			PH_START: begin
				if (ctl_b.in_token) begin
					ctl_l = end_token(ctl_b);
					ev_l  = token_emits(ctl_b);
					r_l   = token_boundary(ctl_b);
				end
				if (ctl_l.token_count != TOKEN_VERSION) begin
					err = ST_TOKEN_COUNT;
				end else if (ctl_l.method_cand == 3'b000) begin
					err = ST_BAD_METHOD;
				end else if (!ctl_l.version_match) begin
					err = ST_BAD_VERSION;
				end
				ctl_l.error_code = err;
				ctl_l.phase      = (err != ST_OK) ? PH_ERROR : PH_KEY;
			end
			PH_KEY: begin
				if (!ctl_b.line_has_bytes) begin
					ctl_l.phase = PH_BODY;
				end else begin
					ctl_l.error_code = ST_NO_COLON;
					ctl_l.phase      = PH_ERROR;
				end
			end
			PH_VALUE: begin
				ev_l          = 1'b1;
				r_l.kind      = KIND_VALUE;
				r_l.is_boundary = 1'b1;
				ctl_l.phase   = PH_KEY;
			end
			default: begin
			end
		endcase
		ctl_l.line_has_bytes = 1'b0;
		ctl_l.value_started  = 1'b0;
	end

	always_comb begin
		if (!active) begin
			ctl_post = ctl_q;
			gap_post = gap_q;
		end else if (line_end) begin
			ctl_post = ctl_l;
			gap_post = '0;
		end else if (item.byte_value == CH_CR) begin
			ctl_post = ctl_b;
			ctl_post.cr_held = 1'b1;
			gap_post = gap_b;
		end else begin
			ctl_post = ctl_c;
			gap_post = gap_c;
		end
	end

	// Gather results in order and pack them into the leading slots
	always_comb begin
		cand_v    = '0;
		cand_r    = '0;
		cand_v[0] = ev_a;
		cand_r[0] = r_a;
		if (ctl_q.phase == PH_BODY) begin
			cand_v[1]            = 1'b1;
			cand_r[1].kind       = KIND_BODY;
			cand_r[1].char_value = item.byte_value;
		end else if (line_end) begin
			cand_v[1] = ev_l;
			cand_r[1] = r_l;
		end else begin
			cand_v[1] = ev_b;
			cand_r[1] = r_b;
		end
		if (item.end_of_request) begin
			cand_v[2]             = (ctl_post.phase == PH_BODY);
			cand_r[2].kind        = KIND_BODY;
			cand_r[2].is_boundary = 1'b1;
			cand_v[3]             = 1'b1;
			cand_r[3].kind        = KIND_STATUS;
			cand_r[3].status      = ctl_post.error_code;
			cand_r[3].tail_dropped = (ctl_post.phase != PH_BODY)
				&& (ctl_post.phase != PH_ERROR)
				&& (ctl_post.line_has_bytes || ctl_post.cr_held);
		end

		step = '0;
		n    = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i] && n < RES_COUNT_BITS'(RES_MAX)) begin
				step.slot[n] = cand_r[i];
				n = n + RES_COUNT_BITS'(1);
			end
		end
		if (n != '0) begin
			step.slot[n - RES_COUNT_BITS'(1)].last_of_run = 1'b1;
		end
		step.count = n;
	end

	assign ctl_next = item.end_of_request ? CTL_RESET : ctl_post;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= CTL_RESET;
			gap_q <= '0;
		end else if (advance) begin
			ctl_q <= ctl_next;
			gap_q <= item.end_of_request ? '0 : gap_post;
		end
	end

endmodule

`default_nettype wire

@@ sv/http_request_stream_parser.sv @@
// Top level of the HTTP request stream parser: input register, step logic, result queue.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------
//   request | req_valid | req_stall | req_item: byte_value, end_of_request
//   result  | res_valid | res_stall | res_item: kind, char_value, is_boundary,
//           |           |           |   gap_spaces, status, tail_dropped, last_of_run
//
// One byte a cycle while nothing stalls: a byte waits in the input register, where the parser
// state is updated and its zero to three results enter a four-entry result queue.
// The first result of a byte is presented once it has been written into the queue.
// A byte leaves the input register only when the queue has room for all its results,
// so bytes causing two or three results, or a stalled result side, slow intake.
// Reset returns the parser to the start line and empties both register and queue.
`timescale 1ns / 1ps
`default_nettype none

module http_request_stream_parser
	import hrsp_pkg::*;
#(
	parameter int GAP_COUNT_BITS = GAP_COUNT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req_item,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item
);

	localparam int FILL_BITS = FIFO_CNT_BITS + 1;

	req_item_t                item_s1;
	logic                     valid_s1;
	step_out_t                step;
	logic                     advance, accept, pop;
	logic [FILL_BITS-1:0]     fill_after;
	logic [RES_COUNT_BITS-1:0] push;

	res_item_t                fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_q, rd_q;
	logic [FIFO_CNT_BITS-1:0] cnt_q;

	hrsp_core #(
		.GAP_COUNT_BITS(GAP_COUNT_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.step    (step)
	);

	assign res_valid = (cnt_q != '0);
	assign res_item  = fifo_q[rd_q];
	assign pop       = res_valid && !res_stall;

	// Hold the byte until every one of its results fits in the queue
	assign fill_after = FILL_BITS'(cnt_q) + FILL_BITS'(step.count) - FILL_BITS'(pop);
	assign advance    = valid_s1 && (fill_after <= FILL_BITS'(FIFO_DEPTH));
	assign push       = advance ? step.count : '0;
	assign req_stall  = valid_s1 && !advance;
	assign accept     = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			wr_q     <= '0;
			rd_q     <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			wr_q  <= wr_q + FIFO_PTR_BITS'(push);
			rd_q  <= rd_q + FIFO_PTR_BITS'(pop);
			cnt_q <= cnt_q + FIFO_CNT_BITS'(push) - FIFO_CNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= req_item;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < RES_MAX; k++) begin
			if (advance && k < int'(step.count)) begin
				fifo_q[FIFO_PTR_BITS'(int'(wr_q) + k)] <= step.slot[k];
			end
		end
	end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the HTTP request stream parser: directed rows, then random requests.
`timescale 1ns / 1ps

module tb;
	import hrsp_pkg::*;

	typedef struct {
		phase_t                        ph;
		logic                          cr_wait;
		logic [2:0]                    tok_n;
		logic                          in_tok;
		logic [2:0]                    meth_live;
		logic [3:0]                    tok_pos;
		logic                          ver_ok;
		logic [GAP_COUNT_BITS_DEF-1:0] gap;
		logic                          val_begun;
		logic                          line_used;
		logic [2:0]                    err;
	} parser_shadow_t;

	// Opening rows; typed rows carry a status that is obvious from the bytes
	typedef struct packed {
		logic [7:0] b;
		logic       eor;
		logic       typed;
		logic [2:0] st;
		logic       tail;
	} opening_row_t;

	localparam int N_OPENING = 22;
	localparam int SPACE_RUN = 20;
	localparam int DRAIN_LIMIT = 4000;
	localparam logic [GAP_COUNT_BITS_DEF-1:0] GAP_TOP = {GAP_COUNT_BITS_DEF{1'b1}};

	localparam opening_row_t OPENING [N_OPENING] = '{
		'{8'h20, 1'b1, 1'b1, ST_OK, 1'b1},
		'{CH_CR, 1'b1, 1'b1, ST_OK, 1'b1},
		'{CH_CR, 1'b0, 1'b0, ST_OK, 1'b0},
		'{CH_LF, 1'b1, 1'b1, ST_TOKEN_COUNT, 1'b0},
		'{8'hFF, 1'b0, 1'b0, ST_OK, 1'b0},
		'{8'h20, 1'b0, 1'b0, ST_OK, 1'b0},
		'{8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{8'h09, 1'b0, 1'b0, ST_OK, 1'b0},
		'{"x",   1'b0, 1'b0, ST_OK, 1'b0},
		'{CH_CR, 1'b0, 1'b0, ST_OK, 1'b0},
		'{CH_LF, 1'b1, 1'b0, ST_OK, 1'b0},
		'{"G",   1'b0, 1'b0, ST_OK, 1'b0},
		'{"E",   1'b0, 1'b0, ST_OK, 1'b0},
		'{"T",   1'b0, 1'b0, ST_OK, 1'b0},
		'{8'h20, 1'b0, 1'b0, ST_OK, 1'b0},
		'{"a",   1'b0, 1'b0, ST_OK, 1'b0},
		'{CH_CR, 1'b0, 1'b0, ST_OK, 1'b0},
		'{"b",   1'b0, 1'b0, ST_OK, 1'b0},
		'{CH_CR, 1'b0, 1'b0, ST_OK, 1'b0},
		'{CH_LF, 1'b0, 1'b0, ST_OK, 1'b0},
		'{"Z",   1'b1, 1'b1, ST_BAD_VERSION, 1'b0},
		'{8'hFF, 1'b1, 1'b0, ST_OK, 1'b0}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;

	parser_shadow_t shadow;
	res_item_t      step_buf[$];
	res_item_t      expected_results[$];
	logic [7:0]     req_bytes[$];
	int unsigned    send_idle_pct = 0;
	int unsigned    recv_idle_pct = 0;
	int unsigned    error_count = 0;
	int unsigned    fed_items = 0;
	int unsigned    results_seen = 0;
	int unsigned    requests_sent = 0;

	http_request_stream_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------- prediction

	function automatic logic [47:0] method_word(input int m);
		case (m)
			0:       return "GET";
			1:       return "POST";
			default: return "DELETE";
		endcase
	endfunction

	function automatic int method_size(input int m);
		case (m)
			0:       return 3;
			1:       return 4;
			default: return 6;
		endcase
	endfunction

	function automatic logic blank_char(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= 8'h09 && c <= CH_CR);
	endfunction

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic void reset_shadow();
		shadow.ph        = PH_START;
		shadow.cr_wait   = 1'b0;
		shadow.tok_n     = 3'd0;
		shadow.in_tok    = 1'b0;
		shadow.meth_live = METHOD_ALL;
		shadow.tok_pos   = 4'd0;
		shadow.ver_ok    = 1'b1;
		shadow.gap       = '0;
		shadow.val_begun = 1'b0;
		shadow.line_used = 1'b0;
		shadow.err       = ST_OK;
	endfunction

	function automatic void put_res(input logic [2:0] k, input logic [7:0] ch, input logic bnd,
			input logic [GAP_OUT_BITS-1:0] gap, input logic [2:0] st, input logic tail);
		res_item_t r;
		r = '0;
		r.kind         = k;
		r.char_value   = ch;
		r.is_boundary  = bnd;
		r.gap_spaces   = gap;
		r.status       = st;
		r.tail_dropped = tail;
		if (step_buf.size() < RES_MAX)
			step_buf.push_back(r);
	endfunction

	function automatic void close_token();
		logic [2:0] fit;
		fit = '0;
		shadow.in_tok = 1'b0;
		if (shadow.tok_n == TOKEN_METHOD) begin
			for (int m = 0; m < 3; m++)
				fit[m] = (shadow.tok_pos == method_size(m));
			shadow.meth_live &= fit;
		end else if (shadow.tok_n == TOKEN_VERSION && shadow.tok_pos != VERSION_LEN) begin
			shadow.ver_ok = 1'b0;
		end
		if (shadow.tok_n >= TOKEN_METHOD && shadow.tok_n <= TOKEN_VERSION)
			put_res(shadow.tok_n - 3'd1, 8'h00, 1'b1, '0, ST_OK, 1'b0);
	endfunction

	function automatic void start_line_char(input logic [7:0] c);
		logic [63:0] ver;
		logic [47:0] w;
		int          len;
		ver = "HTTP/1.1";
		shadow.line_used = 1'b1;
		if (blank_char(c)) begin
			if (shadow.in_tok)
				close_token();
		end else begin
			if (!shadow.in_tok) begin
				shadow.in_tok  = 1'b1;
				shadow.tok_pos = 4'd0;
				if (shadow.tok_n < TOKEN_CAP)
					shadow.tok_n++;
			end
			if (shadow.tok_n == TOKEN_METHOD) begin
				for (int m = 0; m < 3; m++) begin
					w   = method_word(m);
					len = method_size(m);
					if (shadow.tok_pos >= len)
						shadow.meth_live[m] = 1'b0;
					else if (w[8*(len-1-shadow.tok_pos) +: 8] != c)
						shadow.meth_live[m] = 1'b0;
				end
			end else if (shadow.tok_n == TOKEN_VERSION) begin
				if (shadow.tok_pos >= VERSION_LEN)
					shadow.ver_ok = 1'b0;
				else if (ver[8*(7-shadow.tok_pos) +: 8] != c)
					shadow.ver_ok = 1'b0;
			end
			if (shadow.tok_pos < POS_CAP)
				shadow.tok_pos++;
			if (shadow.tok_n <= TOKEN_VERSION)
				put_res(shadow.tok_n - 3'd1, c, 1'b0, '0, ST_OK, 1'b0);
		end
	endfunction

	function automatic void field_char(input logic [7:0] c);
		case (shadow.ph)
			PH_START: start_line_char(c);
			PH_KEY: begin
				shadow.line_used = 1'b1;
				if (c == CH_COLON) begin
					put_res(KIND_KEY, 8'h00, 1'b1, '0, ST_OK, 1'b0);
					shadow.ph        = PH_VALUE;
					shadow.val_begun = 1'b0;
					shadow.gap       = '0;
				end else begin
					put_res(KIND_KEY, fold_case(c), 1'b0, '0, ST_OK, 1'b0);
				end
			end
			PH_VALUE: begin
				shadow.line_used = 1'b1;
				if (c == CH_SPACE) begin
					if (shadow.val_begun && shadow.gap != GAP_TOP)
						shadow.gap++;
				end else begin
					put_res(KIND_VALUE, fold_case(c), 1'b0, shadow.gap, ST_OK, 1'b0);
					shadow.gap       = '0;
					shadow.val_begun = 1'b1;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void finish_line();
		case (shadow.ph)
			PH_START: begin
				if (shadow.in_tok)
					close_token();
				if (shadow.tok_n != TOKEN_VERSION)
					shadow.err = ST_TOKEN_COUNT;
				else if (shadow.meth_live == 3'b000)
					shadow.err = ST_BAD_METHOD;
				else if (!shadow.ver_ok)
					shadow.err = ST_BAD_VERSION;
				shadow.ph = (shadow.err != ST_OK) ? PH_ERROR : PH_KEY;
			end
			PH_KEY: begin
				if (!shadow.line_used) begin
					shadow.ph = PH_BODY;
				end else begin
					shadow.err = ST_NO_COLON;
					shadow.ph  = PH_ERROR;
				end
			end
			PH_VALUE: begin
				put_res(KIND_VALUE, 8'h00, 1'b1, '0, ST_OK, 1'b0);
				shadow.ph = PH_KEY;
			end
			default: ;
		endcase
		shadow.line_used = 1'b0;
		shadow.val_begun = 1'b0;
		shadow.gap       = '0;
	endfunction

	// Work out the results of one byte into step_buf
	function automatic void parse_byte(input logic [7:0] c, input logic eor);
		logic      handled;
		logic      tail;
		res_item_t lastr;
		step_buf.delete();
		handled = 1'b0;
		tail    = 1'b0;
		if (shadow.ph == PH_BODY) begin
			put_res(KIND_BODY, c, 1'b0, '0, ST_OK, 1'b0);
		end else if (shadow.ph != PH_ERROR) begin
			if (shadow.cr_wait) begin
				shadow.cr_wait = 1'b0;
				if (c == CH_LF) begin
					finish_line();
					handled = 1'b1;
				end else begin
					field_char(CH_CR);
				end
			end
			if (!handled) begin
				if (c == CH_CR)
					shadow.cr_wait = 1'b1;
				else
					field_char(c);
			end
		end
		if (eor) begin
			if (shadow.ph == PH_BODY)
				put_res(KIND_BODY, 8'h00, 1'b1, '0, ST_OK, 1'b0);
			else if (shadow.ph != PH_ERROR && (shadow.line_used || shadow.cr_wait))
				tail = 1'b1;
			put_res(KIND_STATUS, 8'h00, 1'b0, '0, shadow.err, tail);
			reset_shadow();
		end
		if (step_buf.size() != 0) begin
			lastr = step_buf.pop_back();
			lastr.last_of_run = 1'b1;
			step_buf.push_back(lastr);
		end
	endfunction

	// ---------------------------------------------------------------- driving

	always @(posedge clk) begin
		if (!arst_n)
			res_stall <= 1'b0;
		else
			res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_byte(input logic [7:0] b, input logic eor, input logic literal,
			input res_item_t lit);
		req_item_t it;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		it.byte_value     = b;
		it.end_of_request = eor;
		req_valid <= 1'b1;
		req_item  <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		fed_items++;
		parse_byte(b, eor);
		if (literal) begin
			expected_results.push_back(lit);
		end else begin
			foreach (step_buf[i])
				expected_results.push_back(step_buf[i]);
		end
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------- request building

	function automatic logic [7:0] rand_byte(input int lo, input int hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			req_bytes.push_back(s[i]);
	endfunction

	function automatic void add_crlf();
		req_bytes.push_back(CH_CR);
		req_bytes.push_back(CH_LF);
	endfunction

	function automatic void add_token_chars(input int n);
		repeat (n) req_bytes.push_back(rand_byte(33, 126));
	endfunction

	function automatic void add_blank_run();
		int n;
		int roll;
		n = $urandom_range(2, 1);
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < 60) begin
				req_bytes.push_back(CH_SPACE);
			end else if (roll < 70) begin
				req_bytes.push_back(8'h09);
			end else if (roll < 78) begin
				req_bytes.push_back(CH_LF);
			end else if (roll < 84) begin
				req_bytes.push_back(8'h0B);
			end else if (roll < 90) begin
				req_bytes.push_back(8'h0C);
			end else begin
				// lone CR, kept away from a following LF
				req_bytes.push_back(CH_CR);
				req_bytes.push_back(CH_SPACE);
			end
		end
	endfunction

	function automatic void add_method();
		int roll;
		roll = $urandom_range(99);
		if (roll < 78) begin
			case ($urandom_range(2))
				0:       add_text("GET");
				1:       add_text("POST");
				default: add_text("DELETE");
			endcase
		end else if (roll < 84) begin
			add_text("get");
		end else if (roll < 88) begin
			add_text("POS");
		end else if (roll < 92) begin
			add_text("DELETES");
		end else begin
			add_token_chars($urandom_range(7, 1));
		end
	endfunction

	function automatic void add_version();
		int roll;
		roll = $urandom_range(99);
		if (roll < 85)
			add_text("HTTP/1.1");
		else if (roll < 90)
			add_text("HTTP/1.0");
		else if (roll < 94)
			add_text("http/1.1");
		else if (roll < 97)
			add_text("HTTP/1.11");
		else
			add_text("HTTP/1");
	endfunction

	function automatic void add_start_line();
		int shape;
		int uri_len;
		shape   = $urandom_range(99);
		uri_len = ($urandom_range(7) == 0) ? $urandom_range(18, 1) : $urandom_range(5, 1);
		if ($urandom_range(7) == 0)
			add_blank_run();
		add_method();
		if (shape >= 8) begin
			add_blank_run();
			add_token_chars(uri_len);
		end
		add_blank_run();
		add_version();
		if (shape >= 92) begin
			add_blank_run();
			add_token_chars($urandom_range(4, 1));
		end
		if ($urandom_range(7) == 0)
			add_blank_run();
		add_crlf();
	endfunction

	function automatic void add_key_char();
		logic [7:0] c;
		if ($urandom_range(14) == 0) begin
			if ($urandom_range(1) == 0) begin
				req_bytes.push_back(CH_LF);
			end else begin
				req_bytes.push_back(CH_CR);
				req_bytes.push_back("a");
			end
		end else begin
			c = rand_byte(32, 126);
			req_bytes.push_back((c == CH_COLON) ? 8'h4B : c);
		end
	endfunction

	function automatic void add_header_line();
		int words;
		if ($urandom_range(4) == 0) begin
			repeat ($urandom_range(4, 1)) add_key_char();
		end else begin
			repeat ($urandom_range(5)) add_key_char();
			req_bytes.push_back(CH_COLON);
			repeat ($urandom_range(3)) req_bytes.push_back(CH_SPACE);
			words = $urandom_range(3);
			for (int w = 0; w < words; w++) begin
				if (w > 0)
					repeat ($urandom_range(4, 1)) req_bytes.push_back(CH_SPACE);
				repeat ($urandom_range(4, 1)) req_bytes.push_back(rand_byte(33, 126));
			end
			repeat ($urandom_range(3)) req_bytes.push_back(CH_SPACE);
		end
		add_crlf();
	endfunction

	function automatic void build_request();
		int cut;
		req_bytes.delete();
		if ($urandom_range(99) < 12) begin
			repeat ($urandom_range(8, 1)) req_bytes.push_back(rand_byte(0, 255));
		end else begin
			add_start_line();
			repeat ($urandom_range(2)) add_header_line();
			if ($urandom_range(9) != 0) begin
				add_crlf();
				repeat ($urandom_range(4)) req_bytes.push_back(rand_byte(0, 255));
			end
			// cut the request short now and then
			if ($urandom_range(9) == 0) begin
				cut = $urandom_range(req_bytes.size(), 1);
				while (req_bytes.size() > cut)
					void'(req_bytes.pop_back());
			end
		end
	endfunction

	task automatic send_queue();
		for (int i = 0; i < req_bytes.size(); i++) begin
			if ($urandom_range(59) == 0)
				hold_until_drained();
			send_byte(req_bytes[i], i == req_bytes.size() - 1, 1'b0, '0);
		end
		requests_sent++;
	endtask

	task automatic run_random(input int unsigned target);
		int unsigned base;
		base = fed_items;
		while (fed_items - base < target) begin
			build_request();
			send_queue();
		end
	endtask

	// One value with a long inner space run, then a header without a colon
	task automatic send_gap_request();
		req_bytes.delete();
		add_text("GET / HTTP/1.1");
		add_crlf();
		add_text("Lk: a");
		repeat (SPACE_RUN) req_bytes.push_back(CH_SPACE);
		add_text("B");
		add_crlf();
		add_text("Zz");
		add_crlf();
		add_text(".");
		send_queue();
	endtask

	// ---------------------------------------------------------------- checking

	task automatic flag_field(input string name, input logic [15:0] want, input logic [15:0] got);
		error_count++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
	endtask

	always @(posedge clk) begin
		res_item_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				error_count++;
				$display("%0t: result with none expected, expected nothing, actual kind %0d char %02h",
					$time, res_item.kind, res_item.char_value);
			end else begin
				want = expected_results.pop_front();
				if (res_item.kind !== want.kind)
					flag_field("kind", 16'(want.kind), 16'(res_item.kind));
				if (res_item.char_value !== want.char_value)
					flag_field("char_value", 16'(want.char_value), 16'(res_item.char_value));
				if (res_item.is_boundary !== want.is_boundary)
					flag_field("is_boundary", 16'(want.is_boundary),
						16'(res_item.is_boundary));
				if (res_item.gap_spaces !== want.gap_spaces)
					flag_field("gap_spaces", want.gap_spaces, res_item.gap_spaces);
				if (res_item.status !== want.status)
					flag_field("status", 16'(want.status), 16'(res_item.status));
				if (res_item.tail_dropped !== want.tail_dropped)
					flag_field("tail_dropped", 16'(want.tail_dropped),
						16'(res_item.tail_dropped));
				if (res_item.last_of_run !== want.last_of_run)
					flag_field("last_of_run", 16'(want.last_of_run),
						16'(res_item.last_of_run));
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		res_item_t lit;
		int        waited;
		reset_shadow();
		send_idle_pct = 26;
		recv_idle_pct = 50;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_OPENING; i++) begin
			lit              = '0;
			lit.kind         = KIND_STATUS;
			lit.status       = OPENING[i].st;
			lit.tail_dropped = OPENING[i].tail;
			lit.last_of_run  = 1'b1;
			send_byte(OPENING[i].b, OPENING[i].eor, OPENING[i].typed, lit);
		end
		requests_sent += 6;
		run_random(130);

		hold_until_drained();
		send_idle_pct = 50;
		recv_idle_pct = 26;
		run_random(130);

		hold_until_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(130);
		send_gap_request();
		req_valid <= 1'b0;

		waited = 0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		// let any late transaction show up
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			error_count++;
			$display("%0t: %0d results expected, actual 0 arrived", $time,
				expected_results.size());
		end

		$display("Run: %0d requests, %0d bytes sent, %0d results checked.",
			requests_sent, fed_items, results_seen);
		$display("Mixed sender and receiver idling, every status, a long inner space run.");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Timeout: the run did not finish in time");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
